/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the watermark merger.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/wmm_pkg.sv */
// ----------------------------------------------------------------------------
// Watermark merger package
// Types, codes and sizes shared by the watermark merger modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wmm_pkg;

	localparam int STREAM_COUNT = 8;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = IDX_W + 1;
	localparam int WM_W         = 64;

	localparam logic [1:0] CMD_IDLE   = 2'd0;
	localparam logic [1:0] CMD_MARK   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic KIND_WM   = 1'b0;
	localparam logic KIND_IDLE = 1'b1;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(STREAM_COUNT);

	typedef struct packed {
		logic [1:0]      cmd;
		logic [IDX_W-1:0] input_index;
		logic [WM_W-1:0] watermark;
	} wmm_in_t;

	typedef struct packed {
		logic            marker_kind;
		logic [WM_W-1:0] marker_value;
	} wmm_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DECIDE
	} wmm_state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic scan_clear;
		logic scan_step;
		logic decide;
	} wmm_ctl_t;

	typedef struct packed {
		logic ignore;
		logic scan_last;
	} wmm_sts_t;

endpackage

`default_nettype wire

/* design/wmm_ctrl.sv */
// ----------------------------------------------------------------------------
// Watermark merger controller
// Sequences capture, update, scan and emit decision; ignored events end at update.
// ----------------------------------------------------------------------------
`default_nettype none

module wmm_ctrl import wmm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire wmm_sts_t sts,
	output wmm_ctl_t      ctl
);

	wmm_state_t state_q;
	wmm_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_next = sts.ignore ? ST_IDLE : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			ST_UPDATE: begin
				ctl.update     = !sts.ignore;
				ctl.scan_clear = 1'b1;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
			end
			ST_DECIDE: begin
				ctl.decide = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/wmm_dpath.sv */
// ----------------------------------------------------------------------------
// Watermark merger datapath
// Per-input state, sequential minimum scan and emitted-marker bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module wmm_dpath import wmm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wmm_in_t          item,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	input  wire wmm_ctl_t         ctl,
	output wmm_sts_t              sts,
	output logic                  done,
	output wmm_out_t              result
);

	logic [CNT_W-1:0]        active_q;
	wmm_in_t                 item_q;
	logic [WM_W-1:0]         marks_q [STREAM_COUNT];
	logic [STREAM_COUNT-1:0] present_q;
	logic [STREAM_COUNT-1:0] idle_q;
	logic [STREAM_COUNT-1:0] fin_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    acc_all_idle_q;
	logic                    acc_min_set_q;
	logic                    acc_all_fin_q;
	logic [WM_W-1:0]         acc_min_q;
	logic [WM_W-1:0]         last_mark_q;
	logic                    last_present_q;
	logic                    idle_sent_q;
	logic                    done_q;
	wmm_out_t                result_q;

	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] rd_idx;
	logic [WM_W-1:0]  rd_mark;
	logic             emit_idle;
	logic             emit_wm;

	always_comb begin
		if (active_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (active_q > CNT_W'(STREAM_COUNT)) begin
			n_eff = CNT_W'(STREAM_COUNT);
		end else begin
			n_eff = active_q;
		end
	end

	assign rd_idx  = ctl.scan_step ? cnt_q : item_q.input_index;
	assign rd_mark = marks_q[rd_idx];

	assign sts.ignore = ({1'b0, item_q.input_index} >= n_eff)
		|| fin_q[item_q.input_index]
		|| ((item_q.cmd != CMD_IDLE) && (item_q.cmd != CMD_MARK)
			&& (item_q.cmd != CMD_FINISH));
	assign sts.scan_last = ({1'b0, cnt_q} == (n_eff - CNT_W'(1)));

	assign emit_idle = !acc_all_fin_q && acc_all_idle_q && !idle_sent_q;
	assign emit_wm   = !acc_all_fin_q && !acc_all_idle_q && acc_min_set_q
		&& (!last_present_q || (acc_min_q > last_mark_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update && (item_q.cmd == CMD_MARK)
			&& (!present_q[item_q.input_index] || (item_q.watermark > rd_mark))) begin
			marks_q[item_q.input_index] <= item_q.watermark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			idle_q    <= '0;
			fin_q     <= '0;
		end else if (ctl.update) begin
			case (item_q.cmd)
				CMD_IDLE: begin
					idle_q[item_q.input_index] <= 1'b1;
				end
				CMD_MARK: begin
					idle_q[item_q.input_index]    <= 1'b0;
					present_q[item_q.input_index] <= 1'b1;
				end
				CMD_FINISH: begin
					fin_q[item_q.input_index] <= 1'b1;
				end
				default: begin
					fin_q <= fin_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_clear) begin
			cnt_q          <= '0;
			acc_all_idle_q <= 1'b1;
			acc_min_set_q  <= 1'b0;
			acc_all_fin_q  <= 1'b1;
			acc_min_q      <= '0;
		end else if (ctl.scan_step) begin
			cnt_q         <= cnt_q + IDX_W'(1);
			acc_all_fin_q <= acc_all_fin_q && fin_q[cnt_q];
			if (!idle_q[cnt_q]) begin
				acc_all_idle_q <= 1'b0;
				if (acc_all_idle_q) begin
					acc_min_set_q <= present_q[cnt_q];
					acc_min_q     <= rd_mark;
				end else begin
					acc_min_set_q <= acc_min_set_q && present_q[cnt_q];
					if (present_q[cnt_q] && (rd_mark < acc_min_q)) begin
						acc_min_q <= rd_mark;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_present_q <= 1'b0;
			idle_sent_q    <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= ctl.decide && (emit_idle || emit_wm);
			if (ctl.decide && emit_idle) begin
				idle_sent_q <= 1'b1;
			end else if (ctl.decide && emit_wm) begin
				idle_sent_q    <= 1'b0;
				last_present_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decide && emit_wm) begin
			last_mark_q <= acc_min_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decide) begin
			result_q.marker_kind  <= emit_idle ? KIND_IDLE : KIND_WM;
			result_q.marker_value <= emit_idle ? '0 : acc_min_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

/* design/watermark_min_merger.sv */
// ----------------------------------------------------------------------------
// Watermark minimum merger
// Merges per-input event-time watermarks into one broadcast marker stream.
// ----------------------------------------------------------------------------
// An event is transferred on a rising edge with start high and busy low. It
// carries a command (idle, watermark, finished), an input index and a value.
// busy stays high while the event is processed. An ignored event (inactive
// index, finished input, unknown command) ends after the update state. Any
// other event passes through the update state, a scan of each active input
// through the shared compare unit, the decision state and the strobe cycle;
// start may be high again in the strobe cycle. A result, if any, is presented
// on result for exactly one cycle with done high, and busy is low in that
// cycle. The receiver cannot stall it.
// The active input count is written through cfg_valid/cfg_data; cfg_ready is
// always high and writes are expected only while busy is low.
// Reset clears all per-input flags and emitted-marker history at once and sets
// the active input count to eight; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module watermark_min_merger import wmm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire wmm_in_t          item,
	output logic                  done,
	output wmm_out_t              result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	wmm_ctl_t ctl;
	wmm_sts_t sts;
	logic     idle_strobe;

	assign cfg_ready   = 1'b1;
	assign idle_strobe = done && (result.marker_kind == KIND_IDLE);

	wmm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	wmm_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.sts      (sts),
		.done     (done),
		.result   (result)
	);

	`ASSERT_CLK(a_done_not_busy, clk, arst_n, done |-> !busy)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_single_result, clk, arst_n, done, !done)
	`ASSERT_CLK(a_idle_zero, clk, arst_n, idle_strobe |-> (result.marker_value == '0))

endmodule

`default_nettype wire

/* test/watermark_min_merger_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Watermark minimum merger testbench
// Drives idle, watermark and finish events through the command port in random
// bursts. Predicts each broadcast marker from an internal copy of the merger
// state and checks every strobed result in order. Walks through several
// active input counts, including the out-of-range ones.
// ----------------------------------------------------------------------------

module watermark_min_merger_test;
	import wmm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int LIST_DEPTH    = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	wmm_in_t item = '0;
	logic done;
	wmm_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	wmm_in_t pending_events[LIST_DEPTH];
	logic [11:0] pend_wr = '0;
	logic [11:0] pend_rd = '0;
	wmm_out_t merged_marks[LIST_DEPTH];
	logic [11:0] mark_wr = '0;
	logic [11:0] mark_rd = '0;

	logic [CNT_W-1:0] active_cfg = ACTIVE_RESET;
	bit [WM_W-1:0] input_mark[STREAM_COUNT];
	bit input_has_mark[STREAM_COUNT];
	bit input_idle[STREAM_COUNT];
	bit input_done[STREAM_COUNT];
	bit [WM_W-1:0] sent_mark;
	bit sent_valid;
	bit idle_sent;

	bit [WM_W-1:0] mark_base = 64'd300;
	int sender_burst = 1;
	int sender_gap = 0;
	int mismatches = 0;
	int cycle_count = 0;

	watermark_min_merger dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned active_span(input logic [CNT_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > STREAM_COUNT)
			return STREAM_COUNT;
		return int'(v);
	endfunction

	function automatic bit predict_marker(input wmm_in_t ev, output wmm_out_t mk);
		int unsigned span;
		int unsigned n_done;
		bit any_live;
		bit any_unset;
		bit [WM_W-1:0] low_mark;
		span = active_span(active_cfg);
		mk = '0;
		if (ev.input_index >= span || input_done[ev.input_index])
			return 1'b0;
		case (ev.cmd)
			CMD_IDLE: input_idle[ev.input_index] = 1'b1;
			CMD_MARK: begin
				input_idle[ev.input_index] = 1'b0;
				if (!input_has_mark[ev.input_index] ||
						ev.watermark > input_mark[ev.input_index]) begin
					input_mark[ev.input_index] = ev.watermark;
					input_has_mark[ev.input_index] = 1'b1;
				end
			end
			CMD_FINISH: input_done[ev.input_index] = 1'b1;
			default: return 1'b0;
		endcase
		n_done = 0;
		any_live = 1'b0;
		any_unset = 1'b0;
		low_mark = '1;
		for (int k = 0; k < span; k++) begin
			if (input_done[k])
				n_done++;
			if (!input_idle[k]) begin
				any_live = 1'b1;
				if (!input_has_mark[k])
					any_unset = 1'b1;
				else if (input_mark[k] < low_mark)
					low_mark = input_mark[k];
			end
		end
		if (n_done == span)
			return 1'b0;
		if (!any_live) begin
			if (idle_sent)
				return 1'b0;
			idle_sent = 1'b1;
			mk.marker_kind = KIND_IDLE;
			mk.marker_value = '0;
			return 1'b1;
		end
		if (any_unset || (sent_valid && low_mark <= sent_mark))
			return 1'b0;
		sent_mark = low_mark;
		sent_valid = 1'b1;
		idle_sent = 1'b0;
		mk.marker_kind = KIND_WM;
		mk.marker_value = low_mark;
		return 1'b1;
	endfunction

	function automatic wmm_in_t random_event(input bit may_finish);
		wmm_in_t ev;
		int unsigned pick;
		int unsigned span;
		span = active_span(active_cfg);
		pick = $urandom_range(0, 99);
		ev.watermark = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			ev.input_index = IDX_W'($urandom);
		else
			ev.input_index = IDX_W'($urandom_range(0, span - 1));
		if (pick < 30)
			ev.cmd = CMD_IDLE;
		else if (pick < 34)
			ev.cmd = CMD_UNUSED;
		else if (may_finish && pick < 37)
			ev.cmd = CMD_FINISH;
		else
			ev.cmd = CMD_MARK;
		if (ev.cmd == CMD_MARK) begin
			mark_base += $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0)
				ev.watermark = mark_base - $urandom_range(0, 20);
			else
				ev.watermark = mark_base + $urandom_range(0, 12);
		end
		return ev;
	endfunction

	task automatic add_event(input wmm_in_t ev);
		pending_events[pend_wr] = ev;
		pend_wr = pend_wr + 12'd1;
	endtask

	task automatic queue_event(input logic [1:0] c, input int idx, input logic [WM_W-1:0] wm);
		add_event('{cmd: c, input_index: IDX_W'(idx), watermark: wm});
	endtask

	task automatic queue_random(input int count, input bit may_finish);
		repeat (count)
			add_event(random_event(may_finish));
	endtask

	task automatic set_active_count(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		active_cfg = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pend_wr != pend_rd || start || busy || mark_wr != mark_rd);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		wmm_out_t mk;
		if (arst_n) begin
			if (start && !busy) begin
				if (predict_marker(item, mk)) begin
					merged_marks[mark_wr] = mk;
					mark_wr = mark_wr + 12'd1;
				end
			end
			if (!start || !busy) begin
				if (sender_gap > 0) begin
					sender_gap--;
					start <= 1'b0;
				end else if (pend_wr != pend_rd) begin
					item <= pending_events[pend_rd];
					pend_rd = pend_rd + 12'd1;
					start <= 1'b1;
					if (sender_burst > 1) begin
						sender_burst--;
					end else begin
						sender_burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
						sender_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		wmm_out_t want;
		if (arst_n && done) begin
			if (mark_wr == mark_rd) begin
				note_mismatch($sformatf("unexpected marker: kind %0d value %0h",
					result.marker_kind, result.marker_value));
			end else begin
				want = merged_marks[mark_rd];
				mark_rd = mark_rd + 12'd1;
				if (result.marker_kind !== want.marker_kind)
					note_mismatch($sformatf("marker_kind: expected %0d, got %0d",
						want.marker_kind, result.marker_kind));
				if (result.marker_value !== want.marker_value)
					note_mismatch($sformatf("marker_value: expected %0h, got %0h",
						want.marker_value, result.marker_value));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_event(CMD_IDLE, 0, '1);
		queue_event(CMD_MARK, 0, '0);
		queue_event(CMD_MARK, 7, '1);
		queue_event(CMD_IDLE, 7, 64'h5555_5555_5555_5555);
		queue_event(CMD_FINISH, 7, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_event(CMD_FINISH, 7, '0);
		queue_event(CMD_MARK, 7, 64'd5);
		queue_event(CMD_UNUSED, 1, 64'd9);
		for (int k = 1; k <= 6; k++)
			queue_event(CMD_IDLE, k, '0);
		queue_event(CMD_IDLE, 0, '0);
		queue_event(CMD_IDLE, 0, '0);
		queue_event(CMD_MARK, 3, 64'd100);
		queue_event(CMD_MARK, 3, 64'd50);
		queue_event(CMD_MARK, 2, 64'd200);
		drain();

		set_active_count(4'd0);
		queue_event(CMD_MARK, 1, 64'd500);
		queue_event(CMD_MARK, 0, 64'd7);
		queue_random(150, 1'b0);
		drain();

		set_active_count(4'd8);
		queue_random(500, 1'b0);
		drain();

		set_active_count(4'd1);
		queue_random(150, 1'b0);
		drain();

		set_active_count(4'd15);
		queue_random(300, 1'b0);
		drain();

		set_active_count(4'd5);
		queue_random(250, 1'b0);
		drain();

		set_active_count(4'd9);
		queue_random(150, 1'b0);
		drain();

		set_active_count(4'd2);
		queue_random(150, 1'b0);
		drain();

		set_active_count(4'd1);
		queue_event(CMD_FINISH, 0, '1);
		queue_event(CMD_MARK, 0, mark_base + 64'd1000);
		queue_event(CMD_IDLE, 0, '0);
		drain();

		set_active_count(4'd3);
		queue_random(200, 1'b1);
		drain();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/wmm_pkg.sv
design/wmm_ctrl.sv
design/wmm_dpath.sv
design/watermark_min_merger.sv
test/watermark_min_merger_test.sv
